// ===== rtl/core/chdr_pkg.sv =====
// Package for the chunk packet header parser: parse phase encoding,
// field kind and status codes, and the state and result item structs.
// No dependencies.
package chdr_pkg;

   // Field kinds as reported on the result channel
   localparam logic [3:0] KIND_ID      = 4'd0;
   localparam logic [3:0] KIND_CHUNK   = 4'd1;
   localparam logic [3:0] KIND_TOTAL   = 4'd2;
   localparam logic [3:0] KIND_TLEN    = 4'd3;
   localparam logic [3:0] KIND_TYPE    = 4'd4;
   localparam logic [3:0] KIND_SIZE    = 4'd5;
   localparam logic [3:0] KIND_FLAG    = 4'd6;
   localparam logic [3:0] KIND_SALT    = 4'd7;
   localparam logic [3:0] KIND_NONCE   = 4'd8;
   localparam logic [3:0] KIND_PAYLOAD = 4'd9;

   // Status codes carried on the last item of a packet
   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_TOO_SMALL  = 3'd1;
   localparam logic [2:0] STAT_TYPE_OVR   = 3'd2;
   localparam logic [2:0] STAT_SIZE_TRUNC = 3'd3;
   localparam logic [2:0] STAT_META_TRUNC = 3'd4;

   // Fixed header: three ids, type length, file size
   localparam logic [4:0] MIN_HEADER = 5'd24;

   localparam logic [7:0] FLAG_CLEAR = 8'd0;
   localparam logic [7:0] FLAG_SET   = 8'd1;

   // Parse phase, one-hot
   typedef enum logic [8:0] {
      PH_ID      = 9'b000000001,
      PH_CHUNK   = 9'b000000010,
      PH_TOTAL   = 9'b000000100,
      PH_TLEN    = 9'b000001000,
      PH_TYPE    = 9'b000010000,
      PH_SIZE    = 9'b000100000,
      PH_FLAG    = 9'b001000000,
      PH_META    = 9'b010000000,
      PH_PAYLOAD = 9'b100000000
   } phase_type;

   // Per-packet parser state (salt/nonce count kept apart, its width follows parameters)
   typedef struct packed {
      phase_type   phase;
      logic [2:0]  fcount;
      logic [4:0]  seen;
      logic [31:0] type_left;
      logic [63:0] asm_value;
      logic        enc;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:     PH_ID,
      fcount:    3'd0,
      seen:      5'd0,
      type_left: 32'd0,
      asm_value: 64'd0,
      enc:       1'b0
   };

   // One result item
   typedef struct packed {
      logic [3:0]  field_kind;
      logic [7:0]  byte_value;
      logic        field_complete;
      logic [63:0] field_value;
      logic        encrypted;
      logic        packet_end;
      logic [2:0]  status;
   } rsp_item_type;

   // Field kind reported while an integer field is being gathered
   function automatic logic [3:0] int_phase_kind(input phase_type ph);
      logic [3:0] k;
      k = KIND_PAYLOAD;
      case (ph)
         PH_ID:    k = KIND_ID;
         PH_CHUNK: k = KIND_CHUNK;
         PH_TOTAL: k = KIND_TOTAL;
         PH_TLEN:  k = KIND_TLEN;
         PH_SIZE:  k = KIND_SIZE;
         default:  k = KIND_PAYLOAD;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/core/chdr_parse.sv =====
// Single-byte parse step: from the current parser state and one byte,
// computes the next state and the result item. Depends on chdr_pkg.
module chdr_parse
   import chdr_pkg::*;
#(
   parameter int SALT_BYTES  = 16,
   parameter int NONCE_BYTES = 12,
   parameter int MetaW       = $clog2(SALT_BYTES + NONCE_BYTES + 1)
) (
   input  parse_state_type   state_cur,
   input  logic [MetaW-1:0]  meta_cur,
   input  logic [7:0]        data_byte,
   input  logic              last_byte,
   output parse_state_type   state_nxt,
   output logic [MetaW-1:0]  meta_nxt,
   output rsp_item_type      result
);

   localparam logic [MetaW-1:0] MetaTotal = MetaW'(SALT_BYTES + NONCE_BYTES);
   localparam logic [MetaW-1:0] NonceCnt  = MetaW'(NONCE_BYTES);

   parse_state_type   st;
   logic [MetaW-1:0]  meta;
   logic [63:0]       acc;
   logic [2:0]        cnt_inc;
   logic              int_done;
   logic [31:0]       type_dec;
   logic [MetaW-1:0]  meta_dec;

   always_comb begin
      st        = state_cur;
      meta      = meta_cur;
      acc       = state_cur.asm_value | ({56'd0, data_byte} << {state_cur.fcount, 3'b000});
      cnt_inc   = state_cur.fcount + 3'd1;
      int_done  = (state_cur.phase == PH_SIZE) ? (cnt_inc == 3'd0) : (cnt_inc == 3'd4);
      type_dec  = state_cur.type_left - 32'd1;
      meta_dec  = (meta_cur != '0) ? (meta_cur - MetaW'(1)) : meta_cur;

      result                = '0;
      result.field_kind     = KIND_PAYLOAD;
      result.byte_value     = data_byte;
      result.packet_end     = last_byte;
      result.status         = STAT_OK;

      // Phase step
      case (state_cur.phase)
         PH_ID, PH_CHUNK, PH_TOTAL, PH_TLEN, PH_SIZE: begin
            result.field_kind = int_phase_kind(state_cur.phase);
            st.asm_value      = acc;
            st.fcount         = cnt_inc;
            if (int_done) begin
               result.field_complete = 1'b1;
               result.field_value    = acc;
               st.asm_value          = '0;
               st.fcount             = '0;
               case (state_cur.phase)
                  PH_ID:    st.phase = PH_CHUNK;
                  PH_CHUNK: st.phase = PH_TOTAL;
                  PH_TOTAL: st.phase = PH_TLEN;
                  PH_TLEN: begin
                     st.type_left = acc[31:0];
                     st.phase     = (acc[31:0] == 32'd0) ? PH_SIZE : PH_TYPE;
                  end
                  default:  st.phase = PH_FLAG;
               endcase
            end
         end
         PH_TYPE: begin
            result.field_kind = KIND_TYPE;
            st.type_left      = type_dec;
            if (type_dec == 32'd0) begin
               st.phase = PH_SIZE;
            end
         end
         PH_FLAG: begin
            if (data_byte == FLAG_CLEAR) begin
               result.field_kind = KIND_FLAG;
               st.phase          = PH_PAYLOAD;
            end else if (data_byte == FLAG_SET) begin
               result.field_kind = KIND_FLAG;
               st.enc            = 1'b1;
               meta              = MetaTotal;
               st.phase          = PH_META;
            end else begin
               // unknown flag value: rest of packet is payload
               st.phase = PH_PAYLOAD;
            end
         end
         PH_META: begin
            result.field_kind = (meta_cur > NonceCnt) ? KIND_SALT : KIND_NONCE;
            meta              = meta_dec;
            if (meta_dec == '0) begin
               st.phase = PH_PAYLOAD;
            end
         end
         default: begin
            st.phase = PH_PAYLOAD;
         end
      endcase

      // Byte count, saturating at the fixed header size
      st.seen = (state_cur.seen >= MIN_HEADER) ? MIN_HEADER : (state_cur.seen + 5'd1);

      result.encrypted = st.enc;

      // End of packet: status by priority, then back to reset
      if (last_byte) begin
         if (st.seen < MIN_HEADER) begin
            result.status = STAT_TOO_SMALL;
         end else if (st.phase == PH_TYPE) begin
            result.status = STAT_TYPE_OVR;
         end else if (st.phase == PH_ID || st.phase == PH_CHUNK || st.phase == PH_TOTAL ||
                      st.phase == PH_TLEN || st.phase == PH_SIZE) begin
            result.status = STAT_SIZE_TRUNC;
         end else if (st.phase == PH_META) begin
            result.status = STAT_META_TRUNC;
         end else begin
            result.status = STAT_OK;
         end
         st   = STATE_RESET;
         meta = '0;
      end

      state_nxt = st;
      meta_nxt  = meta;
   end

endmodule

// ===== rtl/core/chunk_packet_header_parser.sv =====
// Chunk packet header parser: tags each packet byte with its header field.
// Each byte passes the input register, then the result register; the parse step
// sits between the two, and the input register holds while the result one is full.
// Throughput: one byte per cycle while rsp_tready stays high.
// Reset: synchronous, active high; clears both valid flags and returns the
// parser to expecting a packet id.
// Depends on chdr_pkg and chdr_parse.
module chunk_packet_header_parser
   import chdr_pkg::*;
#(
   parameter int SALT_BYTES  = 16,
   parameter int NONCE_BYTES = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [7:0] byte_value, [8] field_complete,
                                    // [72:9] field_value, [73] encrypted,
                                    // [76:74] status, [79:77] zero
   output logic [3:0]  rsp_tuser,   // [3:0] field_kind
   output logic        rsp_tlast    // packet_end
);

   localparam int MetaW = $clog2(SALT_BYTES + NONCE_BYTES + 1);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_item_type     res_ff, res_in;
   parse_state_type  state_ff, state_in;
   logic [MetaW-1:0] meta_ff, meta_in;
   logic             advance;
   logic             req_fire;

   // Handshake: input register moves into result register when that one frees up
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign req_fire     = req_tvalid && req_tready;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   chdr_parse #(
      .SALT_BYTES  (SALT_BYTES),
      .NONCE_BYTES (NONCE_BYTES),
      .MetaW       (MetaW)
   ) u_parse (
      .state_cur (state_ff),
      .meta_cur  (meta_ff),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .state_nxt (state_in),
      .meta_nxt  (meta_in),
      .result    (res_in)
   );

   // Control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
         meta_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
            meta_ff  <= meta_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   // Output packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = res_ff.field_kind;
   assign rsp_tlast  = res_ff.packet_end;
   assign rsp_tdata  = {3'b000, res_ff.status, res_ff.encrypted, res_ff.field_value,
                        res_ff.field_complete, res_ff.byte_value};

   // A status other than ok only on the last item of a packet
   a_status_on_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !res_ff.packet_end) |-> (res_ff.status == STAT_OK))
      else $error("status set on an item that does not end a packet");

   // Only integer fields complete
   a_complete_kind: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && res_ff.field_complete) |->
         (res_ff.field_kind == KIND_ID || res_ff.field_kind == KIND_CHUNK ||
          res_ff.field_kind == KIND_TOTAL || res_ff.field_kind == KIND_TLEN ||
          res_ff.field_kind == KIND_SIZE))
      else $error("field_complete on a non-integer field");

   // Value is zero unless a field completes
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !res_ff.field_complete) |-> (res_ff.field_value == 64'd0))
      else $error("field_value nonzero without field_complete");

   // Parser is back at its reset state after the last byte of a packet
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (state_ff == STATE_RESET && meta_ff == '0))
      else $error("parser state not cleared after end of packet");

endmodule

// ===== tb/chdr_stream_checker.sv =====
// Result checker for the chunk packet header parser: watches both stream channels,
// predicts the result item for every accepted byte and compares it field by field.
// Depends on chdr_pkg for the field kind, status and phase codes.
`timescale 1ns / 100ps

module chdr_stream_checker
   import chdr_pkg::*;
#(
   parameter int SALT_BYTES  = 16,
   parameter int NONCE_BYTES = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,   // [7:0] byte_value, [8] field_complete,
                                    // [72:9] field_value, [73] encrypted,
                                    // [76:74] status, [79:77] zero
   input  logic [3:0]  rsp_tuser,   // [3:0] field_kind
   input  logic        rsp_tlast,   // packet_end
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);

   localparam int PRINT_LIMIT = 40;

   // Shadow parser state
   phase_type   hdr_phase;
   int          hdr_int_bytes;
   logic [4:0]  hdr_seen;
   logic [31:0] hdr_type_left;
   logic [63:0] hdr_partial;
   logic        hdr_enc;
   int          hdr_meta_left;

   rsp_item_type tagged_byte_q[$];

   task automatic clear_parser();
      hdr_phase     = PH_ID;
      hdr_int_bytes = 0;
      hdr_seen      = '0;
      hdr_type_left = '0;
      hdr_partial   = '0;
      hdr_enc       = 1'b0;
      hdr_meta_left = 0;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("%0t ERROR %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // Tag one packet byte and advance the shadow parser
   task automatic tag_byte(input logic [7:0] b, input logic last, output rsp_item_type r);
      int need;
      r            = '0;
      r.field_kind = KIND_PAYLOAD;
      r.byte_value = b;
      r.status     = STAT_OK;
      case (hdr_phase)
         PH_ID, PH_CHUNK, PH_TOTAL, PH_TLEN, PH_SIZE: begin
            need = (hdr_phase == PH_SIZE) ? 8 : 4;
            case (hdr_phase)
               PH_ID:    r.field_kind = KIND_ID;
               PH_CHUNK: r.field_kind = KIND_CHUNK;
               PH_TOTAL: r.field_kind = KIND_TOTAL;
               PH_TLEN:  r.field_kind = KIND_TLEN;
               default:  r.field_kind = KIND_SIZE;
            endcase
            // little-endian assembly
            hdr_partial = hdr_partial | (64'(b) << (8 * hdr_int_bytes));
            hdr_int_bytes++;
            if (hdr_int_bytes == need) begin
               r.field_complete = 1'b1;
               r.field_value    = hdr_partial;
               hdr_partial      = '0;
               hdr_int_bytes    = 0;
               case (hdr_phase)
                  PH_ID:    hdr_phase = PH_CHUNK;
                  PH_CHUNK: hdr_phase = PH_TOTAL;
                  PH_TOTAL: hdr_phase = PH_TLEN;
                  PH_TLEN: begin
                     hdr_type_left = r.field_value[31:0];
                     hdr_phase = (hdr_type_left == 0) ? PH_SIZE : PH_TYPE;
                  end
                  default:  hdr_phase = PH_FLAG;
               endcase
            end
         end
         PH_TYPE: begin
            r.field_kind = KIND_TYPE;
            hdr_type_left--;
            if (hdr_type_left == 0)
               hdr_phase = PH_SIZE;
         end
         PH_FLAG: begin
            if (b == FLAG_CLEAR) begin
               r.field_kind = KIND_FLAG;
               hdr_phase    = PH_PAYLOAD;
            end else if (b == FLAG_SET) begin
               r.field_kind  = KIND_FLAG;
               hdr_enc       = 1'b1;
               hdr_meta_left = SALT_BYTES + NONCE_BYTES;
               hdr_phase     = PH_META;
            end else begin
               // any other flag value turns the rest into payload
               hdr_phase = PH_PAYLOAD;
            end
         end
         PH_META: begin
            r.field_kind = (hdr_meta_left > NONCE_BYTES) ? KIND_SALT : KIND_NONCE;
            if (hdr_meta_left > 0)
               hdr_meta_left--;
            if (hdr_meta_left == 0)
               hdr_phase = PH_PAYLOAD;
         end
         default: hdr_phase = PH_PAYLOAD;
      endcase

      if (hdr_seen < MIN_HEADER)
         hdr_seen++;
      r.encrypted  = hdr_enc;
      r.packet_end = last;

      // status priority at the last byte
      if (last) begin
         if (hdr_seen < MIN_HEADER)
            r.status = STAT_TOO_SMALL;
         else if (hdr_phase == PH_TYPE)
            r.status = STAT_TYPE_OVR;
         else if (hdr_phase == PH_ID || hdr_phase == PH_CHUNK || hdr_phase == PH_TOTAL ||
                  hdr_phase == PH_TLEN || hdr_phase == PH_SIZE)
            r.status = STAT_SIZE_TRUNC;
         else if (hdr_phase == PH_META)
            r.status = STAT_META_TRUNC;
         clear_parser();
      end
   endtask

   // Predict on accepted bytes, compare on accepted results
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         clear_parser();
         tagged_byte_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            tag_byte(req_tdata, req_tlast, want);
            tagged_byte_q.insert(tagged_byte_q.size(), want);
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            got.field_kind     = rsp_tuser;
            got.byte_value     = rsp_tdata[7:0];
            got.field_complete = rsp_tdata[8];
            got.field_value    = rsp_tdata[72:9];
            got.encrypted      = rsp_tdata[73];
            got.status         = rsp_tdata[76:74];
            got.packet_end     = rsp_tlast;
            if (tagged_byte_q.size() == 0) begin
               report_mismatch("result with no byte pending", 64'(got.byte_value), '0);
            end else begin
               want = tagged_byte_q.pop_front();
               if (got.field_kind !== want.field_kind)
                  report_mismatch("field_kind", 64'(got.field_kind), 64'(want.field_kind));
               if (got.byte_value !== want.byte_value)
                  report_mismatch("byte_value", 64'(got.byte_value), 64'(want.byte_value));
               if (got.field_complete !== want.field_complete)
                  report_mismatch("field_complete", 64'(got.field_complete),
                                  64'(want.field_complete));
               if (got.field_value !== want.field_value)
                  report_mismatch("field_value", got.field_value, want.field_value);
               if (got.encrypted !== want.encrypted)
                  report_mismatch("encrypted", 64'(got.encrypted), 64'(want.encrypted));
               if (got.packet_end !== want.packet_end)
                  report_mismatch("packet_end", 64'(got.packet_end), 64'(want.packet_end));
               if (got.status !== want.status)
                  report_mismatch("status", 64'(got.status), 64'(want.status));
               if (rsp_tdata[79:77] !== 3'b000)
                  report_mismatch("tdata pad bits", 64'(rsp_tdata[79:77]), '0);
            end
         end
      end
      pending_count = tagged_byte_q.size();
   end

endmodule

// ===== tb/tb_chunk_packet_header_parser.sv =====
// Top of the chunk packet header parser testbench: clock, reset, packet stimulus
// with random gaps and stalls, and the verdict.
// Depends on chdr_pkg, chunk_packet_header_parser and chdr_stream_checker.
`timescale 1ns / 100ps

module tb_chunk_packet_header_parser;
   import chdr_pkg::*;

   localparam int SALT_BYTES  = 16;
   localparam int NONCE_BYTES = 12;
   localparam int BYTE_TARGET = 400;
   localparam int DRAIN_CYCLES = 20;

   // Packet shapes for the random part
   typedef enum int {
      SHAPE_PLAIN, SHAPE_NO_TAIL, SHAPE_ENCRYPTED, SHAPE_META_CUT, SHAPE_ODD_FLAG,
      SHAPE_TYPE_CUT, SHAPE_SIZE_CUT, SHAPE_TOO_SMALL, SHAPE_NOISE
   } pkt_shape_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;    // [7:0] data_byte
   logic        req_tlast  = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [79:0] rsp_tdata;            // [7:0] byte_value, [8] field_complete,
                                      // [72:9] field_value, [73] encrypted,
                                      // [76:74] status, [79:77] zero
   logic [3:0]  rsp_tuser;            // [3:0] field_kind
   logic        rsp_tlast;            // packet_end

   logic        burst = 1'b0;         // no gaps on either side while set
   int          ready_hold = 0;
   int          stall_len;
   int          fail_count;
   int          pending_count;
   int          result_count;
   int          bytes_sent = 0;
   int          pkt_count = 0;
   logic [7:0]  pkt_bytes[$];

   chunk_packet_header_parser #(
      .SALT_BYTES  (SALT_BYTES),
      .NONCE_BYTES (NONCE_BYTES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   chdr_stream_checker #(
      .SALT_BYTES  (SALT_BYTES),
      .NONCE_BYTES (NONCE_BYTES)
   ) u_chk (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #2_000_000;
      $display("chunk_packet_header_parser: mismatch");
      $finish;
   end

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      else if (r == 1)
         return '1;
      return {$urandom, $urandom};
   endfunction

   // Receiver stalls
   always @(posedge clock) begin
      if (burst) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_tready) begin
         stall_len = pick_gap();
         if (stall_len > 0) begin
            rsp_tready <= 1'b0;
            ready_hold <= stall_len - 1;
         end else begin
            ready_hold <= $urandom_range(0, 8);
         end
      end else begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 10);
      end
   end

   // Add one byte at the end of the packet being built
   task automatic append_byte(input logic [7:0] b);
      pkt_bytes.insert(pkt_bytes.size(), b);
   endtask

   task automatic push_le(input logic [63:0] v, input int n);
      for (int i = 0; i < n; i++)
         append_byte(v[8*i +: 8]);
   endtask

   // Offer one byte; valid stays high when the next byte follows without a gap
   task automatic send_item(input logic [7:0] b, input logic last);
      int gap;
      logic took;
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      bytes_sent++;
   endtask

   task automatic send_packet();
      foreach (pkt_bytes[i])
         send_item(pkt_bytes[i], i == pkt_bytes.size() - 1);
      pkt_count++;
   endtask

   // Hold off the sender until every tagged byte has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      pkt_shape_type shape;
      logic [31:0] tlen;
      int          keep;
      int          size_keep;
      int          cut;
      int          r;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: one-byte packet, then a bare header with extreme values
      pkt_bytes.delete();
      append_byte(8'hFF);
      send_packet();
      pkt_bytes.delete();
      push_le(64'hFFFF_FFFF, 4);
      push_le(64'h0, 4);
      push_le(64'h8000_0001, 4);
      push_le(64'h0, 4);                   // zero type length
      push_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
      append_byte(FLAG_CLEAR);
      send_packet();
      wait_drained();

      // Random packets: each shape once, then weighted toward well-formed ones
      while (bytes_sent < BYTE_TARGET) begin
         if (pkt_count - 2 <= int'(SHAPE_NOISE)) begin
            shape = pkt_shape_type'(pkt_count - 2);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 25)      shape = SHAPE_PLAIN;
            else if (r < 35) shape = SHAPE_NO_TAIL;
            else if (r < 50) shape = SHAPE_ENCRYPTED;
            else if (r < 60) shape = SHAPE_META_CUT;
            else if (r < 70) shape = SHAPE_ODD_FLAG;
            else if (r < 78) shape = SHAPE_TYPE_CUT;
            else if (r < 86) shape = SHAPE_SIZE_CUT;
            else if (r < 93) shape = SHAPE_TOO_SMALL;
            else             shape = SHAPE_NOISE;
         end
         burst <= (pkt_count % 5 == 4);
         if (pkt_count == 8)
            wait_drained();

         pkt_bytes.delete();
         if (shape == SHAPE_NOISE) begin
            repeat ($urandom_range(1, 40)) append_byte(8'($urandom_range(0, 255)));
         end else begin
            size_keep = 8;
            if (shape == SHAPE_TYPE_CUT) begin
               // type string longer than what arrives, sometimes absurdly long
               if ($urandom_range(0, 3) == 0) begin
                  tlen = $urandom | 32'h0100_0000;
                  keep = $urandom_range(8, 30);
               end else begin
                  tlen = $urandom_range(9, 40);
                  keep = $urandom_range(8, tlen - 1);
               end
            end else if (shape == SHAPE_SIZE_CUT) begin
               tlen = $urandom_range(2, 6);
               keep = tlen;
               size_keep = $urandom_range(8 - tlen, 7);
            end else begin
               tlen = ($urandom_range(0, 9) < 4) ? 32'd0 : 32'($urandom_range(1, 10));
               keep = tlen;
            end
            push_le(pick_value(), 4);
            push_le(pick_value(), 4);
            push_le(pick_value(), 4);
            push_le(64'(tlen), 4);
            repeat (keep) append_byte(8'($urandom_range(0, 255)));
            if (shape != SHAPE_TYPE_CUT)
               push_le(pick_value(), size_keep);
            case (shape)
               SHAPE_PLAIN, SHAPE_TOO_SMALL: begin
                  append_byte(FLAG_CLEAR);
                  repeat ($urandom_range(0, 8)) append_byte(8'($urandom_range(0, 255)));
               end
               SHAPE_ENCRYPTED: begin
                  append_byte(FLAG_SET);
                  repeat (SALT_BYTES + NONCE_BYTES + $urandom_range(0, 6))
                     append_byte(8'($urandom_range(0, 255)));
               end
               SHAPE_META_CUT: begin
                  append_byte(FLAG_SET);
                  repeat ($urandom_range(0, SALT_BYTES + NONCE_BYTES - 1))
                     append_byte(8'($urandom_range(0, 255)));
               end
               SHAPE_ODD_FLAG: begin
                  append_byte(8'($urandom_range(2, 255)));
                  repeat ($urandom_range(0, 5)) append_byte(8'($urandom_range(0, 255)));
               end
               default: ;
            endcase
            // short packet: keep only the first bytes of a well-formed one
            if (shape == SHAPE_TOO_SMALL) begin
               cut = $urandom_range(1, 23);
               while (pkt_bytes.size() > cut)
                  void'(pkt_bytes.pop_back());
            end
         end
         send_packet();
      end

      // Drain and let the pipeline settle
      req_tvalid <= 1'b0;
      burst      <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d packets, %0d bytes, %0d result items checked,", pkt_count,
               bytes_sent, result_count);
      $display("all header phases, flag variants and every truncation status.");
      if (fail_count == 0 && pending_count == 0)
         $display("chunk_packet_header_parser: match");
      else
         $display("chunk_packet_header_parser: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/chdr_pkg.sv
rtl/core/chdr_parse.sv
rtl/core/chunk_packet_header_parser.sv
tb/chdr_stream_checker.sv
tb/tb_chunk_packet_header_parser.sv
